// ----- rtl/ifft_pkg.sv -----
package ifft_pkg;

   localparam int POINTS      = 64;
   localparam int LOG_POINTS  = $clog2(POINTS);
   localparam int SAMPLE_BITS = 16;
   localparam int TW_BITS     = 18;
   localparam int TW_ENTRIES  = POINTS / 2;
   localparam int TW_AW       = LOG_POINTS - 1;
   localparam int WORD_BITS   = 2 * SAMPLE_BITS;
   localparam int PROD_BITS   = TW_BITS + SAMPLE_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;

   typedef logic [LOG_POINTS-1:0]          addr_type;
   typedef logic [TW_AW-1:0]               tw_idx_type;
   typedef logic signed [SAMPLE_BITS-1:0]  sample_type;
   typedef logic [WORD_BITS-1:0]           word_type;
   typedef logic signed [TW_BITS-1:0]      tw_type;
   typedef tw_type                         tw_table_type [TW_ENTRIES];

   // cos and sin of 2*pi*k/64 in Q2.15, rounded to nearest, 1.0 is 32768
   localparam tw_table_type TW_COS = '{
      18'sd32768, 18'sd32610, 18'sd32138, 18'sd31357,
      18'sd30274, 18'sd28899, 18'sd27246, 18'sd25330,
      18'sd23170, 18'sd20788, 18'sd18205, 18'sd15447,
      18'sd12540, 18'sd9512,  18'sd6393,  18'sd3212,
      18'sd0,     -18'sd3212, -18'sd6393, -18'sd9512,
      -18'sd12540, -18'sd15447, -18'sd18205, -18'sd20788,
      -18'sd23170, -18'sd25330, -18'sd27246, -18'sd28899,
      -18'sd30274, -18'sd31357, -18'sd32138, -18'sd32610
   };

   localparam tw_table_type TW_SIN = '{
      18'sd0,     18'sd3212,  18'sd6393,  18'sd9512,
      18'sd12540, 18'sd15447, 18'sd18205, 18'sd20788,
      18'sd23170, 18'sd25330, 18'sd27246, 18'sd28899,
      18'sd30274, 18'sd31357, 18'sd32138, 18'sd32610,
      18'sd32768, 18'sd32610, 18'sd32138, 18'sd31357,
      18'sd30274, 18'sd28899, 18'sd27246, 18'sd25330,
      18'sd23170, 18'sd20788, 18'sd18205, 18'sd15447,
      18'sd12540, 18'sd9512,  18'sd6393,  18'sd3212
   };

   typedef enum logic [1:0] {
      WSEL_IN,
      WSEL_TOP,
      WSEL_BOT
   } wsel_type;

   typedef struct packed {
      logic       ram_we;
      addr_type   ram_addr;
      wsel_type   wsel;
      logic       cap_a;
      logic       mul_en;
      logic       sum_en;
      tw_idx_type tw_idx;
      logic       out_load;
      addr_type   out_index;
      logic       out_last;
   } cmd_type;

   function automatic addr_type bit_reverse(addr_type v);
      addr_type r;
      for (int b = 0; b < LOG_POINTS; b++) begin
         r[LOG_POINTS-1-b] = v[b];
      end
      return r;
   endfunction

   // floor(v / 2^16 + 1/2) then clamp to the sample range
   function automatic sample_type round_sat(logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      logic signed [SUM_BITS-17:0] q;
      r = v + (SUM_BITS)'(32768);
      q = r[SUM_BITS-1:16];
      if (q > (SUM_BITS-16)'(signed'((1 << (SAMPLE_BITS-1)) - 1)))
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (q < -(SUM_BITS-16)'(signed'(1 << (SAMPLE_BITS-1))))
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else
         return q[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ----- rtl/ifft_ram.sv -----
module ifft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/ifft_datapath.sv -----
module ifft_datapath (
   input  logic                 clock,
   input  ifft_pkg::cmd_type    cmd,
   input  ifft_pkg::sample_type in_re,
   input  ifft_pkg::sample_type in_im,
   output ifft_pkg::sample_type out_re,
   output ifft_pkg::sample_type out_im,
   output ifft_pkg::addr_type   out_index,
   output logic                 out_last
);
   import ifft_pkg::*;

   word_type   wdata;
   word_type   rdata;
   sample_type rd_re, rd_im;
   sample_type ar_ff, ai_ff;
   logic signed [PROD_BITS-1:0] cbr_ff, sbi_ff, cbi_ff, sbr_ff;
   sample_type tr_ff, ti_ff, ur_ff, ui_ff;
   sample_type ore_ff, oim_ff;
   addr_type   oidx_ff;
   logic       olast_ff;
   tw_type     c, s;
   logic signed [SUM_BITS-1:0] pr, pim, av_re, av_im;

   assign rd_re = rdata[SAMPLE_BITS-1:0];
   assign rd_im = rdata[WORD_BITS-1:SAMPLE_BITS];
   assign c = TW_COS[cmd.tw_idx];
   assign s = TW_SIN[cmd.tw_idx];

   always_comb begin
      unique case (cmd.wsel)
         WSEL_TOP: wdata = {ti_ff, tr_ff};
         WSEL_BOT: wdata = {ui_ff, ur_ff};
         default:  wdata = {in_im, in_re};
      endcase
   end

   ifft_ram #(.WIDTH(WORD_BITS), .DEPTH(POINTS)) u_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .addr  (cmd.ram_addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign pr    = SUM_BITS'(cbr_ff) + SUM_BITS'(sbi_ff);
   assign pim   = SUM_BITS'(cbi_ff) - SUM_BITS'(sbr_ff);
   assign av_re = SUM_BITS'(ar_ff) <<< 15;
   assign av_im = SUM_BITS'(ai_ff) <<< 15;

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         ar_ff <= rd_re;
         ai_ff <= rd_im;
      end
      if (cmd.mul_en) begin
         cbr_ff <= PROD_BITS'(c) * PROD_BITS'(rd_re);
         sbi_ff <= PROD_BITS'(s) * PROD_BITS'(rd_im);
         cbi_ff <= PROD_BITS'(c) * PROD_BITS'(rd_im);
         sbr_ff <= PROD_BITS'(s) * PROD_BITS'(rd_re);
      end
      if (cmd.sum_en) begin
         tr_ff <= round_sat(av_re + pr);
         ti_ff <= round_sat(av_im + pim);
         ur_ff <= round_sat(av_re - pr);
         ui_ff <= round_sat(av_im - pim);
      end
      if (cmd.out_load) begin
         ore_ff   <= rd_re;
         oim_ff   <= rd_im;
         oidx_ff  <= cmd.out_index;
         olast_ff <= cmd.out_last;
      end
   end

   assign out_re    = ore_ff;
   assign out_im    = oim_ff;
   assign out_index = oidx_ff;
   assign out_last  = olast_ff;

endmodule

// ----- rtl/ifft_ctrl.sv -----
module ifft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ifft_pkg::cmd_type cmd
);
   import ifft_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD, S_RA, S_RB, S_MUL, S_SUM, S_WA, S_WB, S_ORD, S_OCAP, S_OWAIT
   } state_type;

   state_type  state_ff;
   addr_type   ld_ff, n_ff;
   tw_idx_type k_ff;
   logic [$clog2(LOG_POINTS)-1:0] s_ff;
   logic       rsp_valid_ff;
   logic       fire;
   addr_type   kw, half, mask, a_addr, b_addr, jw;

   assign fire   = req_valid && (state_ff == S_LOAD);
   assign kw     = addr_type'(k_ff);
   assign half   = addr_type'(1) << s_ff;
   assign mask   = half - addr_type'(1);
   assign jw     = kw & mask;
   assign a_addr = ((kw >> s_ff) << (s_ff + 1'b1)) | jw;
   assign b_addr = a_addr | half;

   always_comb begin
      cmd           = '0;
      cmd.wsel      = WSEL_IN;
      cmd.tw_idx    = tw_idx_type'(jw << (TW_AW - s_ff));
      cmd.out_index = n_ff;
      cmd.out_last  = (n_ff == addr_type'(POINTS - 1));
      cmd.ram_addr  = a_addr;
      unique case (state_ff)
         S_LOAD: begin
            cmd.ram_we   = fire;
            cmd.ram_addr = bit_reverse(ld_ff);
         end
         S_RA:  cmd.ram_addr = a_addr;
         S_RB: begin
            cmd.ram_addr = b_addr;
            cmd.cap_a    = 1'b1;
         end
         S_MUL: cmd.mul_en = 1'b1;
         S_SUM: cmd.sum_en = 1'b1;
         S_WA: begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WSEL_TOP;
         end
         S_WB: begin
            cmd.ram_we   = 1'b1;
            cmd.wsel     = WSEL_BOT;
            cmd.ram_addr = b_addr;
         end
         S_ORD:  cmd.ram_addr = addr_type'(0) - n_ff;
         S_OCAP: cmd.out_load = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         ld_ff        <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (fire) begin
                  ld_ff <= ld_ff + 1'b1;
                  if (ld_ff == addr_type'(POINTS - 1)) begin
                     k_ff     <= '0;
                     s_ff     <= '0;
                     state_ff <= S_RA;
                  end
               end
            end
            S_RA:  state_ff <= S_RB;
            S_RB:  state_ff <= S_MUL;
            S_MUL: state_ff <= S_SUM;
            S_SUM: state_ff <= S_WA;
            S_WA:  state_ff <= S_WB;
            S_WB: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == tw_idx_type'(TW_ENTRIES - 1)) begin
                  if (s_ff == ($clog2(LOG_POINTS))'(LOG_POINTS - 1)) begin
                     n_ff     <= '0;
                     state_ff <= S_ORD;
                  end else begin
                     s_ff     <= s_ff + 1'b1;
                     state_ff <= S_RA;
                  end
               end else begin
                  state_ff <= S_RA;
               end
            end
            S_ORD: state_ff <= S_OCAP;
            S_OCAP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OWAIT;
            end
            S_OWAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  n_ff         <= n_ff + 1'b1;
                  state_ff     <= (n_ff == addr_type'(POINTS - 1)) ? S_LOAD : S_ORD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> (fire || state_ff == S_WA || state_ff == S_WB))
      else $error("sample store written outside load or butterfly write");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OWAIT && rsp_ready && n_ff == addr_type'(POINTS - 1)) |=> req_ready)
      else $error("no return to loading after last transfer");

endmodule

// ----- rtl/complex_ifft_64_point_top.sv -----
// 64-point inverse FFT, Q1.15 complex samples. The block loads 64 frequency samples
// (one per transfer, written in bit-reversed order into a single-port sample RAM), then
// runs 6 radix-2 stages of 32 butterflies each, halving every stage for the 1/N scale,
// and emits the 64 time samples in natural order with index and last flag.
// A butterfly runs on the shared single-port RAM as two reads, a multiply, an
// add/round and two writes, one after another. In the output phase each result is read
// from the RAM, captured in the output register and held until the consumer takes it.
// Input is not taken during compute or output.
module complex_ifft_64_point_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ifft_pkg::sample_type req_in_re,
   input  ifft_pkg::sample_type req_in_im,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ifft_pkg::sample_type rsp_out_re,
   output ifft_pkg::sample_type rsp_out_im,
   output ifft_pkg::addr_type   rsp_out_index,
   output logic                 rsp_last
);
   import ifft_pkg::*;

   cmd_type cmd;

   ifft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ifft_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .in_re     (req_in_re),
      .in_im     (req_in_im),
      .out_re    (rsp_out_re),
      .out_im    (rsp_out_im),
      .out_index (rsp_out_index),
      .out_last  (rsp_last)
   );

endmodule
